/* rtl/rhfp_pkg.sv */
// Shared constants, types and helpers for the RFID hex frame parser.
`default_nettype none

package rhfp_pkg;

    localparam int unsigned CHAR_W              = 8;
    localparam int unsigned STORE_DEPTH         = 11;
    localparam int unsigned DIGIT_COUNT         = STORE_DEPTH - 1;
    localparam int unsigned INDEX_W             = 5;
    localparam int unsigned INDEX_LIMIT_DEFAULT = 29;
    localparam int unsigned TAG_W               = 4 * DIGIT_COUNT;
    localparam int unsigned ALIAS_W             = 12;
    localparam int unsigned OUT_PAYLOAD_W       = TAG_W + ALIAS_W;
    localparam int unsigned OUT_TDATA_W         = ((OUT_PAYLOAD_W + 7) / 8) * 8;
    localparam int unsigned APB_ADDR_W          = 3;
    localparam int unsigned APB_DATA_W          = 32;

    localparam logic [CHAR_W-1:0] BYTE_START = 8'h02;
    localparam logic [CHAR_W-1:0] BYTE_END   = 8'h03;

    localparam logic REG_NODE_ALIAS = 1'b0;

    typedef logic [CHAR_W-1:0] char_t;
    typedef char_t [STORE_DEPTH-1:0] store_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    typedef struct packed {
        logic             ok;
        logic [TAG_W-1:0] tag;
    } decode_t;

    typedef struct packed {
        logic  step;
        char_t rx_byte;
    } step_t;

    function automatic hex_t hex_value(input char_t c);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= "0" && c <= "9")
        begin
            h.value = 4'(c - "0");
        end
        else if (c >= "A" && c <= "F")
        begin
            h.value = 4'(c - "A" + 8'd10);
        end
        else if (c >= "a" && c <= "f")
        begin
            h.value = 4'(c - "a" + 8'd10);
        end
        else
        begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

/* rtl/rfid_hex_frame_parser_unit.sv */
// Top level of the RFID hex frame parser: stream ports, config port, pipeline.
//
//  channel   dir   handshake                 payload
//  s_axis    in    s_axis_tvalid/tready      tdata[7:0] rx_byte
//  m_axis    out   m_axis_tvalid/tready      tdata[39:0] tag_id, [51:40] source_alias
//  apb       in    psel/penable/pready       node_alias at address 0
//
//  One byte per cycle unless stalled; an end byte passes the input register, then its tag loads the output register.
//  The path runs through the input register and the result register.
//  Reset clears the buffer, write index, alias and both valid flags.
//  A held result stalls only an end byte that decodes to a tag; other bytes proceed.
`default_nettype none

module rfid_hex_frame_parser_unit #(
    parameter int unsigned INDEX_LIMIT = rhfp_pkg::INDEX_LIMIT_DEFAULT
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [7:0]                           s_axis_tdata,  // [7:0] rx_byte
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [rhfp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [39:0] tag_id, [51:40] source_alias
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [rhfp_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire  [rhfp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rhfp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    logic                                in_valid_reg;
    rhfp_pkg::char_t                     in_byte_reg;
    logic                                out_valid_reg;
    logic [rhfp_pkg::OUT_TDATA_W-1:0]    out_data_reg;
    logic [rhfp_pkg::ALIAS_W-1:0]        alias_reg;

    rhfp_pkg::step_t                     step_in;
    rhfp_pkg::store_t                    store;
    rhfp_pkg::decode_t                   decoded;
    logic [rhfp_pkg::INDEX_W-1:0]        write_index;
    logic                                emit;
    logic                                stall;
    logic                                step;
    logic                                cfg_write;

    assign emit  = in_valid_reg && (in_byte_reg == rhfp_pkg::BYTE_END) && decoded.ok;
    assign stall = emit && out_valid_reg && !m_axis_tready;
    assign step  = in_valid_reg && !stall;

    assign s_axis_tready = !in_valid_reg || !stall;

    assign step_in.step    = step;
    assign step_in.rx_byte = in_byte_reg;

    rhfp_frame_store #(
        .INDEX_LIMIT (INDEX_LIMIT)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_in     (step_in),
        .store       (store),
        .write_index (write_index)
    );

    rhfp_hex_decode u_decode (
        .store  (store),
        .result (decoded)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_data_reg <= rhfp_pkg::OUT_TDATA_W'({alias_reg, decoded.tag});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alias_reg <= '0;
        end
        else if (cfg_write && paddr[2] == rhfp_pkg::REG_NODE_ALIAS)
        begin
            alias_reg <= pwdata[rhfp_pkg::ALIAS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rhfp_pkg::REG_NODE_ALIAS)
                    ? rhfp_pkg::APB_DATA_W'(alias_reg) : '0;

    a_index_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        write_index <= rhfp_pkg::INDEX_W'(INDEX_LIMIT))
        else $error("write index beyond limit");

    a_emit_loads_output : assert property (@(posedge clk) disable iff (!rst_n)
        step && emit |=> m_axis_tvalid)
        else $error("decoded tag not presented");

    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a held result");

    a_stall_holds_byte : assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled byte lost");

endmodule

`default_nettype wire

/* rtl/rhfp_frame_store.sv */
// Character buffer and write index of the frame parser.
`default_nettype none

module rhfp_frame_store #(
    parameter int unsigned INDEX_LIMIT = rhfp_pkg::INDEX_LIMIT_DEFAULT
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  rhfp_pkg::step_t                  step_in,
    output rhfp_pkg::store_t                 store,
    output logic [rhfp_pkg::INDEX_W-1:0]     write_index
);

    localparam logic [rhfp_pkg::INDEX_W-1:0] LIMIT = rhfp_pkg::INDEX_W'(INDEX_LIMIT);

    rhfp_pkg::store_t                store_reg;
    logic [rhfp_pkg::INDEX_W-1:0]    index_reg;
    logic [rhfp_pkg::INDEX_W-1:0]    index_next;
    logic [rhfp_pkg::INDEX_W-1:0]    index_eff;
    logic                            is_start;
    logic                            is_end;

    assign is_start  = (step_in.rx_byte == rhfp_pkg::BYTE_START);
    assign is_end    = (step_in.rx_byte == rhfp_pkg::BYTE_END);
    assign index_eff = (index_reg >= LIMIT) ? '0 : index_reg;

    always_comb
    begin
        index_next = index_reg;
        if (step_in.step)
        begin
            if (is_start)
            begin
                index_next = rhfp_pkg::INDEX_W'(1);
            end
            else if (is_end)
            begin
                index_next = '0;
            end
            else
            begin
                index_next = index_eff + rhfp_pkg::INDEX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            store_reg <= '0;
        end
        else
        begin
            index_reg <= index_next;
            for (int k = 0; k < rhfp_pkg::STORE_DEPTH; k++)
            begin
                if (step_in.step)
                begin
                    if (is_start)
                    begin
                        if (k == 0)
                        begin
                            store_reg[k] <= rhfp_pkg::BYTE_START;
                        end
                    end
                    else if (!is_end && index_eff == rhfp_pkg::INDEX_W'(k))
                    begin
                        store_reg[k] <= step_in.rx_byte;
                    end
                end
            end
        end
    end

    assign store       = store_reg;
    assign write_index = index_reg;

endmodule

`default_nettype wire

/* rtl/rhfp_hex_decode.sv */
// Start check and ten-digit hex decode of the buffered frame.
`default_nettype none

module rhfp_hex_decode (
    input  rhfp_pkg::store_t   store,
    output rhfp_pkg::decode_t  result
);

    rhfp_pkg::hex_t [rhfp_pkg::DIGIT_COUNT-1:0] digits;
    logic [rhfp_pkg::DIGIT_COUNT-1:0]           digit_ok;

    always_comb
    begin
        result.tag = '0;
        for (int k = 1; k < rhfp_pkg::STORE_DEPTH; k++)
        begin
            digits[k-1]   = rhfp_pkg::hex_value(store[k]);
            digit_ok[k-1] = digits[k-1].valid;
            result.tag[(rhfp_pkg::STORE_DEPTH-1-k)*4 +: 4] = digits[k-1].value;
        end
        result.ok = (store[0] == rhfp_pkg::BYTE_START) && (&digit_ok);
    end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for the RFID hex frame parser: a table of directed frames, then random traffic.
module testbench;
    import rhfp_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 305;
    localparam int PHASE_COUNT   = 5;
    localparam int MAX_REPORTS   = 10;

    localparam logic [APB_ADDR_W-1:0] ALIAS_ADDR = APB_ADDR_W'(4 * REG_NODE_ALIAS);

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [ALIAS_W-1:0] src;
    } tag_event_t;

    typedef enum logic [1:0] {ROW_MODEL, ROW_NONE, ROW_TAG} row_check_t;

    typedef struct packed {
        char_t              rx;
        row_check_t         chk;
        logic [TAG_W-1:0]   tag;
        logic [ALIAS_W-1:0] src;
    } frame_row_t;

    frame_row_t frame_table [24] = '{
        '{BYTE_END,   ROW_NONE,  '0, '0},
        '{BYTE_START, ROW_MODEL, '0, '0},
        '{"F", ROW_MODEL, '0, '0}, '{"F", ROW_MODEL, '0, '0}, '{"F", ROW_MODEL, '0, '0},
        '{"F", ROW_MODEL, '0, '0}, '{"F", ROW_MODEL, '0, '0}, '{"F", ROW_MODEL, '0, '0},
        '{"F", ROW_MODEL, '0, '0}, '{"F", ROW_MODEL, '0, '0}, '{"F", ROW_MODEL, '0, '0},
        '{"F", ROW_MODEL, '0, '0},
        '{BYTE_END,   ROW_TAG,   40'hFF_FFFF_FFFF, 12'h000},
        '{BYTE_START, ROW_MODEL, '0, '0},
        '{"a", ROW_MODEL, '0, '0}, '{"9", ROW_MODEL, '0, '0}, '{"f", ROW_MODEL, '0, '0},
        '{BYTE_END,   ROW_TAG,   40'hA9_FFFF_FFFF, 12'h000},
        '{BYTE_START, ROW_MODEL, '0, '0},
        '{8'hFF,      ROW_MODEL, '0, '0},
        '{BYTE_END,   ROW_NONE,  '0, '0},
        '{BYTE_START, ROW_MODEL, '0, '0},
        '{8'h00,      ROW_MODEL, '0, '0},
        '{BYTE_END,   ROW_NONE,  '0, '0}
    };

    int          phase_send_idle [PHASE_COUNT] = '{0, 76, 0, 25, 0};
    int          phase_rx_stall  [PHASE_COUNT] = '{0, 0, 76, 25, 0};
    logic [11:0] phase_alias     [PHASE_COUNT] = '{12'hFFF, 12'h000, 12'h000, 12'h5A3, 12'h000};

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] rx_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [39:0] tag_id, [51:40] source_alias
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    char_t              char_buf [STORE_DEPTH];
    logic [INDEX_W-1:0] wr_index;
    logic [ALIAS_W-1:0] cur_alias;
    tag_event_t         pending_tags [$];

    int     fail_count;
    int     send_idle_pct;
    int     rx_stall_pct;
    longint cycle_count;

    rfid_hex_frame_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #CLK_HALF clk = ~clk;

    function automatic bit hex_nibble(input char_t c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9")
        begin
            v = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "A" && c <= "F")
        begin
            v = 4'(c - "A" + 8'd10);
            return 1'b1;
        end
        if (c >= "a" && c <= "f")
        begin
            v = 4'(c - "a" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit advance_parser(input char_t b, output tag_event_t ev);
        logic [3:0]       d;
        logic [TAG_W-1:0] tag;
        bit               ok;
        ev  = '0;
        tag = '0;
        ok  = 1'b1;
        if (b == BYTE_START)
        begin
            char_buf[0] = BYTE_START;
            wr_index    = 1;
            return 1'b0;
        end
        if (b == BYTE_END)
        begin
            wr_index = '0;
            if (char_buf[0] != BYTE_START)
                return 1'b0;
            for (int k = 1; k < STORE_DEPTH; k++)
            begin
                if (!hex_nibble(char_buf[k], d))
                begin
                    ok = 1'b0;
                    d  = 4'd0;
                end
                tag = {tag[TAG_W-5:0], d};
            end
            if (!ok)
                return 1'b0;
            ev.tag = tag;
            ev.src = cur_alias;
            return 1'b1;
        end
        if (wr_index >= INDEX_LIMIT_DEFAULT)
            wr_index = '0;
        if (wr_index < STORE_DEPTH)
            char_buf[wr_index] = b;
        wr_index = wr_index + 1'b1;
        return 1'b0;
    endfunction

    function automatic char_t rand_hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
            return char_t'("0" + v);
        if ($urandom_range(1) == 1)
            return char_t'("A" + v - 10);
        return char_t'("a" + v - 10);
    endfunction

    function automatic char_t rand_plain_char();
        char_t c;
        do
            c = char_t'($urandom_range(255));
        while (c == BYTE_START || c == BYTE_END);
        return c;
    endfunction

    task automatic note_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // hold tvalid across back-to-back beats; drop it only for an idle gap
    task automatic send_beat(input char_t b);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic feed_byte(input char_t b);
        tag_event_t ev;
        send_beat(b);
        if (advance_parser(b, ev))
            pending_tags.push_back(ev);
    endtask

    task automatic send_burst(output int count);
        char_t bytes [$];
        int    kind;
        int    n;
        kind = $urandom_range(99);
        if (kind < 62)
        begin
            bytes.push_back(BYTE_START);
            for (int i = 0; i < DIGIT_COUNT; i++)
                bytes.push_back(($urandom_range(39) == 0) ? rand_plain_char() : rand_hex_char());
            n = $urandom_range(4);
            repeat (n) bytes.push_back(rand_plain_char());
            bytes.push_back(BYTE_END);
        end
        else if (kind < 74)
        begin
            bytes.push_back(BYTE_START);
            n = $urandom_range(DIGIT_COUNT - 1);
            repeat (n) bytes.push_back(rand_hex_char());
            bytes.push_back(BYTE_END);
        end
        else if (kind < 86)
        begin
            n = $urandom_range(8, 1);
            repeat (n) bytes.push_back(char_t'($urandom_range(255)));
        end
        else if (kind < 96)
        begin
            if ($urandom_range(1) == 1)
                bytes.push_back(BYTE_START);
            n = $urandom_range(45, 12);
            repeat (n) bytes.push_back(rand_plain_char());
            bytes.push_back(BYTE_END);
        end
        else
        begin
            bytes.push_back(BYTE_END);
        end
        foreach (bytes[i])
            feed_byte(bytes[i]);
        count = bytes.size();
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_tags.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_alias(input logic [ALIAS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ALIAS_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cur_alias = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[ALIAS_W-1:0] !== value)
            note_mismatch($sformatf("alias readback expected %h got %h",
                                    value, prdata[ALIAS_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        tag_event_t want;
        tag_event_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.tag = m_axis_tdata[TAG_W-1:0];
            got.src = m_axis_tdata[TAG_W +: ALIAS_W];
            if (pending_tags.size() == 0)
            begin
                note_mismatch($sformatf("unexpected beat tag %h src %h", got.tag, got.src));
            end
            else
            begin
                want = pending_tags.pop_front();
                if (got.tag !== want.tag)
                    note_mismatch($sformatf("tag_id expected %h got %h", want.tag, got.tag));
                if (got.src !== want.src)
                    note_mismatch($sformatf("source_alias expected %h got %h",
                                            want.src, got.src));
            end
        end
    end

    initial
    begin
        tag_event_t ev;
        int         sent;
        int         n;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        fail_count    = 0;
        cycle_count   = 0;
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        foreach (char_buf[k])
            char_buf[k] = '0;
        wr_index  = '0;
        cur_alias = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (frame_table[r])
        begin
            send_beat(frame_table[r].rx);
            if (advance_parser(frame_table[r].rx, ev) && frame_table[r].chk == ROW_MODEL)
                pending_tags.push_back(ev);
            if (frame_table[r].chk == ROW_TAG)
                pending_tags.push_back('{frame_table[r].tag, frame_table[r].src});
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_drained();
            if (p == 2 || p == 4)
                set_alias(ALIAS_W'($urandom_range(4095)));
            else
                set_alias(phase_alias[p]);
            send_idle_pct = phase_send_idle[p];
            rx_stall_pct  = phase_rx_stall[p];
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_burst(n);
                sent += n;
            end
        end
        wait_drained();

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
